[src/srm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package srm_pkg;

    // Default length of the register data phase, in bits.
    localparam int DATA_BITS_DEF = 24;
    // Command byte length and width of the returned register value.
    localparam int CMD_BITS = 8;
    localparam int RD_BITS  = 24;

    // Request kinds; the same codes mark the kind of frame in progress.
    typedef logic [1:0] t_req;
    localparam t_req REQ_TICK  = 2'd0;
    localparam t_req REQ_BYTE  = 2'd1;
    localparam t_req REQ_READ  = 2'd2;
    localparam t_req REQ_WRITE = 2'd3;

    // Flag set in the command byte of a register write.
    localparam logic [CMD_BITS-1:0] WRITE_FLAG = 8'h40;

    // One input item: a half-bit tick, possibly carrying a request.
    typedef struct packed {
        t_req                req_type;
        logic [CMD_BITS-1:0] cmd_or_addr;
        logic [RD_BITS-1:0]  write_data;
        logic                miso;
    } t_req_item;

    // One result item: the line levels and status after the tick.
    typedef struct packed {
        logic               sclk;
        logic               mosi;
        logic               cs_n;
        logic               busy_res;
        logic               done_res;
        logic [RD_BITS-1:0] read_data;
    } t_res_item;

endpackage

`default_nettype wire

[src/srm_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module srm_core #(
    parameter int DATA_BITS = srm_pkg::DATA_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_take,
    input  wire srm_pkg::t_req_item i_item,
    output srm_pkg::t_res_item      o_res
);

    localparam int CMD_BITS = srm_pkg::CMD_BITS;
    localparam int RD_BITS  = srm_pkg::RD_BITS;
    localparam int CNT_W    = $clog2(DATA_BITS + CMD_BITS + 1);
    localparam logic [CNT_W-1:0] FRAME_LEN = CNT_W'(DATA_BITS + CMD_BITS);
    localparam logic [CNT_W-1:0] DATA_LEN  = CNT_W'(DATA_BITS);
    localparam logic [CNT_W-1:0] BYTE_LEN  = CNT_W'(CMD_BITS);
    localparam logic [CNT_W-1:0] WORD_LEN  = CNT_W'(RD_BITS);
    localparam logic [RD_BITS-1:0] DMASK =
        (DATA_BITS >= RD_BITS) ? {RD_BITS{1'b1}} : RD_BITS'((64'd1 << DATA_BITS) - 64'd1);

    // Frame state.
    srm_pkg::t_req        r_kind, n_kind;
    logic [CNT_W-1:0]     r_bits, n_bits;
    logic                 r_phase, n_phase;
    logic [CMD_BITS-1:0]  r_cmd, n_cmd;
    logic [RD_BITS-1:0]   r_wdata, n_wdata;
    logic [RD_BITS-1:0]   r_rx, n_rx;
    logic                 r_sel, n_sel;
    logic                 r_mosi, n_mosi;

    logic                 done;
    logic [RD_BITS-1:0]   rd;
    logic [CNT_W-1:0]     bit_idx;
    logic [CNT_W-1:0]     data_len;
    logic [CNT_W-1:0]     cmd_off;
    logic [CMD_BITS-1:0]  cmd;
    logic                 sample;

    // Command byte for a new request.
    always_comb begin
        unique case (i_item.req_type)
            srm_pkg::REQ_READ:  cmd = {i_item.cmd_or_addr[CMD_BITS-2:0], 1'b0};
            srm_pkg::REQ_WRITE: cmd = {i_item.cmd_or_addr[CMD_BITS-2:0], 1'b0}
                                      | srm_pkg::WRITE_FLAG;
            default:            cmd = i_item.cmd_or_addr;
        endcase
    end

    // Bit position within the frame and its offset into the command byte.
    assign bit_idx  = r_bits - 1'b1;
    assign data_len = (r_kind == srm_pkg::REQ_BYTE) ? '0 : DATA_LEN;
    assign cmd_off  = bit_idx - data_len;

    // One tick of the frame sequencer.
    always_comb begin
        n_kind  = r_kind;
        n_bits  = r_bits;
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_wdata = r_wdata;
        n_rx    = r_rx;
        n_sel   = r_sel;
        n_mosi  = r_mosi;
        done    = 1'b0;
        sample  = 1'b0;
        rd      = '0;
        if (r_kind == srm_pkg::REQ_TICK) begin
            // Idle: a request opens a new frame.
            if (i_item.req_type != srm_pkg::REQ_TICK) begin
                n_kind  = i_item.req_type;
                n_cmd   = cmd;
                n_wdata = (i_item.req_type == srm_pkg::REQ_WRITE) ?
                          (i_item.write_data & DMASK) : '0;
                n_rx    = '0;
                n_bits  = (i_item.req_type == srm_pkg::REQ_BYTE) ? BYTE_LEN : FRAME_LEN;
                n_phase = 1'b1;
                n_sel   = 1'b0;
            end
        end else if (r_phase && (r_bits != '0)) begin
            // Low phase: drive the next bit; byte frames and the data bits of a read sample the slave.
            if (bit_idx >= data_len) begin
                n_mosi = r_cmd[cmd_off[2:0]];
                sample = (r_kind == srm_pkg::REQ_BYTE);
            end else if (r_kind == srm_pkg::REQ_READ) begin
                n_mosi = 1'b1;
                sample = 1'b1;
            end else begin
                n_mosi = (bit_idx >= WORD_LEN) ? 1'b0 : r_wdata[bit_idx[4:0]];
            end
            if (sample) begin
                n_rx = {r_rx[RD_BITS-2:0], i_item.miso};
            end
            n_phase = 1'b0;
        end else begin
            // High phase ends a bit; the frame ends with its last bit.
            if (!r_phase) begin
                n_phase = 1'b1;
                n_bits  = bit_idx;
            end
            if (!r_phase ? (bit_idx == '0) : 1'b1) begin
                done    = 1'b1;
                n_sel   = 1'b1;
                n_phase = 1'b1;
                n_kind  = srm_pkg::REQ_TICK;
                n_bits  = '0;
                if (r_kind == srm_pkg::REQ_BYTE) begin
                    rd = {{(RD_BITS-CMD_BITS){1'b0}}, r_rx[CMD_BITS-1:0]};
                end else if (r_kind == srm_pkg::REQ_READ) begin
                    rd = r_rx;
                end
            end
        end
    end

    // Result of this tick.
    assign o_res.sclk      = n_phase;
    assign o_res.mosi      = n_mosi;
    assign o_res.cs_n      = n_sel;
    assign o_res.busy_res  = (n_kind != srm_pkg::REQ_TICK);
    assign o_res.done_res  = done;
    assign o_res.read_data = rd;

    // State registers advance once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= srm_pkg::REQ_TICK;
            r_bits  <= '0;
            r_phase <= 1'b1;
            r_cmd   <= '0;
            r_wdata <= '0;
            r_rx    <= '0;
            r_sel   <= 1'b1;
            r_mosi  <= 1'b0;
        end else if (i_take) begin
            r_kind  <= n_kind;
            r_bits  <= n_bits;
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_wdata <= n_wdata;
            r_rx    <= n_rx;
            r_sel   <= n_sel;
            r_mosi  <= n_mosi;
        end
    end

endmodule

`default_nettype wire

[src/srm_skid.sv]
`timescale 1ns / 1ps
`default_nettype none

module srm_skid (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  wire srm_pkg::t_res_item i_item,
    output logic                    o_valid,
    input  wire                     i_stall,
    output srm_pkg::t_res_item      o_item
);

    logic               r_out_valid;
    logic               r_skid_valid;
    srm_pkg::t_res_item r_out;
    srm_pkg::t_res_item r_skid;
    logic               out_fire;
    logic               in_fire;

    assign out_fire = r_out_valid && !i_stall;
    assign in_fire  = i_valid && !r_skid_valid;
    assign o_stall  = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_item   = r_out;

    // Valid flags of the output register and the skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid <= i_item;
            end else begin
                r_out <= i_item;
            end
        end
    end

endmodule

`default_nettype wire

[src/spi_register_access_master.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_stall     i_in_item  (srm_pkg::t_req_item)
// out       output     o_out_valid / i_out_stall   o_out_item (srm_pkg::t_res_item)
//
// Each item is one half-bit tick and yields one result item, registered as it is taken.
// Unless stalled, one item can be taken per cycle, updating the frame sequencer state.
// A two-entry output stage (register plus skid entry) decouples the two channels.
// Synchronous active-low reset leaves the bus idle: clock high, chip select high.
// While the output stalls, input is taken until the skid entry fills, then stalled.

module spi_register_access_master #(
    parameter int DATA_BITS = srm_pkg::DATA_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire srm_pkg::t_req_item i_in_item,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output srm_pkg::t_res_item      o_out_item
);

    srm_pkg::t_res_item res;
    logic               take;

    assign take = i_in_valid && !o_in_stall;

    // Frame sequencer.
    srm_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_in_item),
        .o_res   (res)
    );

    // Result register with skid entry.
    srm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (res),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire
